// ===== src/etc2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ETC2/EAC decoder package
// Shared types, tables and helpers for the block decoder.
// ----------------------------------------------------------------------------
package etc2_pkg;

   localparam logic [1:0] FMT_RGB8  = 2'd0;
   localparam logic [1:0] FMT_PUNCH = 2'd1;
   localparam logic [1:0] FMT_RGBA8 = 2'd2;

   localparam logic [1:0] MODE_IND    = 2'd0;
   localparam logic [1:0] MODE_T      = 2'd1;
   localparam logic [1:0] MODE_H      = 2'd2;
   localparam logic [1:0] MODE_PLANAR = 2'd3;

   localparam logic [1:0] ADDR_FORMAT = 2'd0;

   // per-block decoded parameters shared by all lanes
   typedef struct packed {
      logic [1:0]  mode;
      logic        clear;
      logic        flip;
      logic [2:0]  tab0;
      logic [2:0]  tab1;
      logic [23:0] base0;   // R 7:0, G 15:8, B 23:16
      logic [23:0] base1;
      logic [95:0] paint;   // four paint colors, 24 bits each
      logic [23:0] org;     // planar origin
      logic [23:0] hor;
      logic [23:0] ver;
      logic [31:0] idx;     // color index bits
      logic        alpha_en;
      logic [7:0]  a_base;
      logic [3:0]  a_mul;
      logic [3:0]  a_tab;
      logic [47:0] a_idx;
   } blk_type;

   function automatic logic [7:0] w4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] w5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] w6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] w7(input logic [6:0] v);
      return {v, v[6]};
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [11:0] v);
      if (v < 0) return 8'd0;
      else if (v > 12'sd255) return 8'd255;
      else return v[7:0];
   endfunction

   function automatic logic signed [8:0] etc_mod(input logic [2:0] t, input logic [1:0] i);
      logic [7:0] m;
      case (t)
         3'd0: m = 8'd2;   3'd1: m = 8'd5;   3'd2: m = 8'd9;   3'd3: m = 8'd13;
         3'd4: m = 8'd18;  3'd5: m = 8'd24;  3'd6: m = 8'd33;  default: m = 8'd47;
      endcase
      if (i[0]) begin
         case (t)
            3'd0: m = 8'd8;   3'd1: m = 8'd17;  3'd2: m = 8'd29;  3'd3: m = 8'd42;
            3'd4: m = 8'd60;  3'd5: m = 8'd80;  3'd6: m = 8'd106; default: m = 8'd183;
         endcase
      end
      return i[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic [6:0] th_dist(input logic [2:0] i);
      case (i)
         3'd0: return 7'd3;   3'd1: return 7'd6;   3'd2: return 7'd11;  3'd3: return 7'd16;
         3'd4: return 7'd23;  3'd5: return 7'd32;  3'd6: return 7'd41;  default: return 7'd64;
      endcase
   endfunction

   function automatic logic signed [4:0] eac_mod(input logic [3:0] t, input logic [2:0] i);
      logic [31:0] r;
      case (t)
         4'd0:  r = {4'd14, 4'd8, 4'd5, 4'd2, 4'd15, 4'd9, 4'd6, 4'd3};
         4'd1:  r = {4'd12, 4'd9, 4'd6, 4'd2, 4'd13, 4'd10, 4'd7, 4'd3};
         4'd2:  r = {4'd12, 4'd7, 4'd4, 4'd1, 4'd13, 4'd8, 4'd5, 4'd2};
         4'd3:  r = {4'd12, 4'd5, 4'd3, 4'd1, 4'd13, 4'd6, 4'd4, 4'd2};
         4'd4:  r = {4'd11, 4'd7, 4'd5, 4'd2, 4'd12, 4'd8, 4'd6, 4'd3};
         4'd5:  r = {4'd10, 4'd8, 4'd6, 4'd2, 4'd11, 4'd9, 4'd7, 4'd3};
         4'd6:  r = {4'd10, 4'd7, 4'd6, 4'd3, 4'd11, 4'd8, 4'd7, 4'd4};
         4'd7:  r = {4'd10, 4'd7, 4'd4, 4'd2, 4'd11, 4'd8, 4'd5, 4'd3};
         4'd8:  r = {4'd9, 4'd7, 4'd5, 4'd1, 4'd10, 4'd8, 4'd6, 4'd2};
         4'd9:  r = {4'd9, 4'd7, 4'd4, 4'd1, 4'd10, 4'd8, 4'd5, 4'd2};
         4'd10: r = {4'd9, 4'd7, 4'd3, 4'd1, 4'd10, 4'd8, 4'd4, 4'd2};
         4'd11: r = {4'd9, 4'd6, 4'd4, 4'd1, 4'd10, 4'd7, 4'd5, 4'd2};
         4'd12: r = {4'd9, 4'd6, 4'd3, 4'd2, 4'd10, 4'd7, 4'd4, 4'd3};
         4'd13: r = {4'd9, 4'd2, 4'd1, 4'd0, 4'd10, 4'd3, 4'd2, 4'd1};
         4'd14: r = {4'd8, 4'd7, 4'd5, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4};
         default: r = {4'd8, 4'd6, 4'd4, 4'd2, 4'd9, 4'd7, 4'd5, 4'd3};
      endcase
      // low nibbles hold magnitudes; entries 0..3 negative, 4..7 positive
      return i[2] ? $signed({1'b0, r[4*i +: 4]}) : -$signed({1'b0, r[4*i +: 4]});
   endfunction

endpackage

// ===== src/etc2_hdr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ETC2 header decode
// Mode select, base, paint and planar colors, indices and alpha fields for one block; registered.
// ----------------------------------------------------------------------------
module etc2_hdr (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       c,
   input  logic [63:0]       w,
   input  logic [1:0]        fmt,
   output etc2_pkg::blk_type blk_ff
);

   etc2_pkg::blk_type blk_in;

   logic              punch, opaque, diffm;
   logic signed [5:0] sr, sg, sb;
   logic              rok, gok, bok;
   logic [23:0]       b0, b1;
   logic [6:0]        d;
   logic [7:0]        p0 [3];
   logic [7:0]        p1 [3];
   logic [7:0]        p2 [3];
   logic [7:0]        p3 [3];
   logic [23:0]       v0, v1;

   always_comb begin
      punch  = fmt == etc2_pkg::FMT_PUNCH;
      opaque = c[33];
      diffm  = punch || opaque;
      sr = $signed({1'b0, c[63:59]}) + $signed({{3{c[58]}}, c[58:56]});
      sg = $signed({1'b0, c[55:51]}) + $signed({{3{c[50]}}, c[50:48]});
      sb = $signed({1'b0, c[47:43]}) + $signed({{3{c[42]}}, c[42:40]});
      rok = sr >= 0 && sr <= 31;
      gok = sg >= 0 && sg <= 31;
      bok = sb >= 0 && sb <= 31;

      blk_in = '0;
      blk_in.clear = punch && !opaque;
      blk_in.flip  = c[32];
      blk_in.tab0  = c[39:37];
      blk_in.tab1  = c[36:34];
      blk_in.idx   = c[31:0];
      blk_in.alpha_en = fmt == etc2_pkg::FMT_RGBA8;
      blk_in.a_base = w[63:56];
      blk_in.a_mul  = w[55:52];
      blk_in.a_tab  = w[51:48];
      blk_in.a_idx  = w[47:0];

      if (!diffm) begin
         b0 = {etc2_pkg::w4(c[47:44]), etc2_pkg::w4(c[55:52]), etc2_pkg::w4(c[63:60])};
         b1 = {etc2_pkg::w4(c[43:40]), etc2_pkg::w4(c[51:48]), etc2_pkg::w4(c[59:56])};
      end else begin
         b0 = {etc2_pkg::w5(c[47:43]), etc2_pkg::w5(c[55:51]), etc2_pkg::w5(c[63:59])};
         b1 = {etc2_pkg::w5(sb[4:0]), etc2_pkg::w5(sg[4:0]), etc2_pkg::w5(sr[4:0])};
      end
      blk_in.base0 = b0;
      blk_in.base1 = b1;

      // T mode
      d = etc2_pkg::th_dist({c[35:34], c[32]});
      p0[0] = etc2_pkg::w4({c[60:59], c[57:56]});
      p0[1] = etc2_pkg::w4(c[55:52]);
      p0[2] = etc2_pkg::w4(c[51:48]);
      p2[0] = etc2_pkg::w4(c[47:44]);
      p2[1] = etc2_pkg::w4(c[43:40]);
      p2[2] = etc2_pkg::w4(c[39:36]);
      for (int k = 0; k < 3; k++) begin
         p1[k] = etc2_pkg::clamp8($signed({4'd0, p2[k]}) + $signed({5'd0, d}));
         p3[k] = etc2_pkg::clamp8($signed({4'd0, p2[k]}) - $signed({5'd0, d}));
      end
      if (!rok) begin
         blk_in.mode = etc2_pkg::MODE_T;
      end else if (!gok) begin
         blk_in.mode = etc2_pkg::MODE_H;
         p0[0] = etc2_pkg::w4(c[62:59]);
         p0[1] = etc2_pkg::w4({c[58:56], c[52]});
         p0[2] = etc2_pkg::w4({c[51], c[49:47]});
         p2[0] = etc2_pkg::w4(c[46:43]);
         p2[1] = etc2_pkg::w4(c[42:39]);
         p2[2] = etc2_pkg::w4(c[38:35]);
         v0 = {p0[0], p0[1], p0[2]};
         v1 = {p2[0], p2[1], p2[2]};
         d = etc2_pkg::th_dist({c[34], c[32], v0 >= v1});
         for (int k = 0; k < 3; k++) begin
            p1[k] = etc2_pkg::clamp8($signed({4'd0, p0[k]}) - $signed({5'd0, d}));
            p3[k] = etc2_pkg::clamp8($signed({4'd0, p2[k]}) - $signed({5'd0, d}));
            p0[k] = etc2_pkg::clamp8($signed({4'd0, p0[k]}) + $signed({5'd0, d}));
            p2[k] = etc2_pkg::clamp8($signed({4'd0, p2[k]}) + $signed({5'd0, d}));
         end
      end else if (!bok) begin
         blk_in.mode = etc2_pkg::MODE_PLANAR;
      end else begin
         blk_in.mode = etc2_pkg::MODE_IND;
      end
      if (!diffm) blk_in.mode = etc2_pkg::MODE_IND;
      v0 = '0;
      v1 = '0;
      blk_in.paint = {p3[2], p3[1], p3[0], p2[2], p2[1], p2[0],
                      p1[2], p1[1], p1[0], p0[2], p0[1], p0[0]};

      blk_in.org = {etc2_pkg::w6({c[48], c[44:43], c[41:39]}),
                    etc2_pkg::w7({c[56], c[54:49]}), etc2_pkg::w6(c[62:57])};
      blk_in.hor = {etc2_pkg::w6(c[24:19]), etc2_pkg::w7(c[31:25]),
                    etc2_pkg::w6({c[38:34], c[32]})};
      blk_in.ver = {etc2_pkg::w6(c[5:0]), etc2_pkg::w7(c[12:6]), etc2_pkg::w6(c[18:13])};
   end

   always_ff @(posedge clock) begin
      if (en) blk_ff <= blk_in;
   end

endmodule

// ===== src/etc2_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ETC2 pixel lane
// Decodes one pixel (fixed column) of the current row; registered output.
// ----------------------------------------------------------------------------
module etc2_lane (
   input  logic              clock,
   input  logic              en,
   input  logic [1:0]        col,
   input  logic [1:0]        row,
   input  etc2_pkg::blk_type blk,
   output logic [31:0]       px_ff
);

   logic [31:0]        px_in;
   logic [3:0]         pn;
   logic [1:0]         ci;
   logic               sub;
   logic signed [8:0]  m;
   logic [23:0]        bs;
   logic [7:0]         ch [3];
   logic signed [12:0] s;
   logic [2:0]         ai;
   logic signed [9:0]  am;
   logic [7:0]         a;
   logic [7:0]         o, h, v;

   always_comb begin
      pn  = {col, row};
      ci  = {blk.idx[16 + pn], blk.idx[pn]};
      sub = blk.flip ? row[1] : col[1];
      m   = etc2_pkg::etc_mod(sub ? blk.tab1 : blk.tab0, ci);
      if (blk.clear && ci == 2'd0) m = '0;
      bs  = sub ? blk.base1 : blk.base0;
      for (int k = 0; k < 3; k++) begin
         o = blk.org[8*k +: 8];
         h = blk.hor[8*k +: 8];
         v = blk.ver[8*k +: 8];
         s = $signed({11'd0, col}) * ($signed({5'd0, h}) - $signed({5'd0, o}))
           + $signed({11'd0, row}) * ($signed({5'd0, v}) - $signed({5'd0, o}))
           + $signed({3'd0, o, 2'd2});
         case (blk.mode)
            etc2_pkg::MODE_IND:
               ch[k] = etc2_pkg::clamp8($signed({4'd0, bs[8*k +: 8]}) + 12'(m));
            etc2_pkg::MODE_PLANAR:
               // arithmetic shift floors the divide by four
               ch[k] = etc2_pkg::clamp8(12'(s >>> 2));
            default:
               ch[k] = blk.paint[24*ci + 8*k +: 8];
         endcase
      end
      // pixel n takes the 3-bit index at bits 47-3n down to 45-3n
      ai = blk.a_idx[45 - 3*pn +: 3];
      am = 10'($signed({1'b0, blk.a_mul}) * etc2_pkg::eac_mod(blk.a_tab, ai));
      a  = etc2_pkg::clamp8($signed({4'd0, blk.a_base}) + 12'(am));
      if (!blk.alpha_en) a = 8'd255;
      px_in = {a, ch[2], ch[1], ch[0]};
      if (blk.mode != etc2_pkg::MODE_PLANAR && blk.clear && ci == 2'd2) px_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en) px_ff <= px_in;
   end

endmodule

// ===== src/etc2_eac_block_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ETC2/EAC block decoder
// The header stage registers an accepted block; the lane stage then registers its rows.
// A new block is accepted as the last row of the previous block enters the lane stage.
// Four pixel lanes decode one row per cycle from registered block header, unless the output stalls.
// Reset: synchronous active high; clears format and all valid flags.
// ----------------------------------------------------------------------------
module etc2_eac_block_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // color_block[63:0], alpha_block[127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // row_index[1:0], px0..px3 at [33:2].. [129:98]
   output logic         rsp_tlast,   // last_row
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [1:0] fmt_ff;
   // stage 1: header registered; stage 2: row lanes -> output
   logic       hv_ff;
   logic [1:0] row_ff;
   logic       ov_ff;
   logic [1:0] orow_ff;
   logic       adv1, hdr_en, hdr_free;
   etc2_pkg::blk_type blk;
   logic [31:0] px [4];

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == etc2_pkg::ADDR_FORMAT) ? {30'd0, fmt_ff} : 32'd0;

   // lane stage advances when a header is held and output is empty or being taken
   assign adv1     = hv_ff && (!ov_ff || rsp_tready);
   assign hdr_free = !hv_ff || (adv1 && row_ff == 2'd3);
   assign req_tready = hdr_free;
   assign hdr_en   = req_tvalid && hdr_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= etc2_pkg::FMT_RGB8;
         hv_ff   <= 1'b0;
         row_ff  <= '0;
         ov_ff   <= 1'b0;
         orow_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == etc2_pkg::ADDR_FORMAT)
            fmt_ff <= csr_pwdata[1:0];
         if (hdr_en) begin
            hv_ff  <= 1'b1;
            row_ff <= '0;
         end else if (adv1) begin
            if (row_ff == 2'd3) hv_ff <= 1'b0;
            row_ff <= row_ff + 2'd1;
         end
         if (adv1) begin
            ov_ff   <= 1'b1;
            orow_ff <= row_ff;
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   etc2_hdr u_hdr (
      .clock (clock),
      .en    (hdr_en),
      .c     (req_tdata[63:0]),
      .w     (req_tdata[127:64]),
      .fmt   (fmt_ff),
      .blk_ff(blk)
   );

   for (genvar i = 0; i < 4; i++) begin : g_lane
      etc2_lane u_lane (
         .clock(clock),
         .en   (adv1),
         .col  (2'(i)),
         .row  (row_ff),
         .blk  (blk),
         .px_ff(px[i])
      );
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, px[3], px[2], px[1], px[0], orow_ff};
   assign rsp_tlast  = orow_ff == 2'd3;

endmodule

// ===== src/etc2_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ETC2 decoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module etc2_chk (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast
);

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[1:0] == 2'd3))
      else $error("tlast mismatch");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
      |-> rsp_tdata[1:0] == $past(rsp_tdata[1:0]) + 2'd1)
      else $error("row order");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[135:130] == 6'd0)
      else $error("padding");

endmodule

bind etc2_eac_block_decoder etc2_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
